/* src/round_robin_task_scheduler_macros.svh */
// Assertion macros shared by the scheduler modules.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication.
`define RRTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

/* src/rrts_pkg.sv */
package rrts_pkg;

   localparam int PID_W    = 11;
   localparam int PRIO_W   = 8;
   localparam int OP_W     = 3;
   localparam int ERR_W    = 3;
   localparam int TST_W    = 3;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int SCAN_W   = 16;

   localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
   localparam logic [OP_W-1:0] OP_SCHED   = 3'd1;
   localparam logic [OP_W-1:0] OP_BLOCK   = 3'd2;
   localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd3;
   localparam logic [OP_W-1:0] OP_YIELD   = 3'd4;
   localparam logic [OP_W-1:0] OP_EXIT    = 3'd5;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd6;

   localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NO_ID       = 3'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NOT_BLOCKED = 3'd3;
   localparam logic [ERR_W-1:0] ERR_NOTHING     = 3'd4;

   localparam logic [TST_W-1:0] TS_RUN     = 3'd0;
   localparam logic [TST_W-1:0] TS_READY   = 3'd1;
   localparam logic [TST_W-1:0] TS_BLOCKED = 3'd2;
   localparam logic [TST_W-1:0] TS_HANGING = 3'd4;
   localparam logic [TST_W-1:0] TS_DIED    = 3'd5;
   localparam logic [TST_W-1:0] TS_ABSENT  = 3'd6;

   localparam logic [KIND_W-1:0] KIND_HANG  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EXTRA = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PID_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PID = 1'b1;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CAPTURE,
      CMD_ERR_UNKNOWN,
      CMD_SCAN,
      CMD_CREATE,
      CMD_BLOCK,
      CMD_REQUEUE,
      CMD_RD_TGT,
      CMD_RD_IDLE,
      CMD_RD_HEAD,
      CMD_IDLE_WAKE,
      CMD_UNBLOCK,
      CMD_POP,
      CMD_SCHED_FAIL,
      CMD_EXIT,
      CMD_QUERY,
      CMD_LOAD_OUT
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            cur_valid;
      logic            tgt_found;
      logic            idle_found;
      logic            count_zero;
      logic            scan_hit;
      logic            scan_last;
      logic            need;
      logic            rsp_busy;
   } dp_status_type;

endpackage

/* src/round_robin_task_scheduler.sv */
// Channel  Handshake              Beat
// req      req_valid/req_ready    opcode, task_pid, priority_req, start_running,
//                                 block_kind, need_schedule
// rsp      rsp_valid/rsp_ready    error_code, result_pid, running_pid, previous_pid,
//                                 switched, task_status, task_priority, slice_left
// csr      csr_write_enable       csr_index, csr_data (no read-back)
//
// One request at a time: create scans the slots in chunks of 16 for the lowest free id.
// Each operation is a controller sequence around the link, status, priority and slice
// memories, which share one read address and whose reads are registered.
// Reset is synchronous; it clears the allocation and ready bits, so no clearing pass.
// A pending response does not stall intake; the next result waits in the last state.
module round_robin_task_scheduler import rrts_pkg::*; #(
   parameter int TASK_SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PID_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [PID_W-1:0]     req_task_pid,
   input  logic [PRIO_W-1:0]    req_priority_req,
   input  logic                 req_start_running,
   input  logic [KIND_W-1:0]    req_block_kind,
   input  logic                 req_need_schedule,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ERR_W-1:0]     rsp_error_code,
   output logic [PID_W-1:0]     rsp_result_pid,
   output logic [PID_W-1:0]     rsp_running_pid,
   output logic [PID_W-1:0]     rsp_previous_pid,
   output logic                 rsp_switched,
   output logic [TST_W-1:0]     rsp_task_status,
   output logic [PRIO_W-1:0]    rsp_task_priority,
   output logic [PRIO_W-1:0]    rsp_slice_left
);

   cmd_type       cmd;
   dp_status_type status;

   rrts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   rrts_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_opcode        (req_opcode),
      .req_task_pid      (req_task_pid),
      .req_priority_req  (req_priority_req),
      .req_start_running (req_start_running),
      .req_block_kind    (req_block_kind),
      .req_need_schedule (req_need_schedule),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_error_code    (rsp_error_code),
      .rsp_result_pid    (rsp_result_pid),
      .rsp_running_pid   (rsp_running_pid),
      .rsp_previous_pid  (rsp_previous_pid),
      .rsp_switched      (rsp_switched),
      .rsp_task_status   (rsp_task_status),
      .rsp_task_priority (rsp_task_priority),
      .rsp_slice_left    (rsp_slice_left),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

/* src/rrts_controller.sv */
`include "round_robin_task_scheduler_macros.svh"

module rrts_controller import rrts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output cmd_type       cmd,
   input  dp_status_type status
);

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_DECODE   = 16'h0002,
      S_SCAN     = 16'h0004,
      S_CREATE   = 16'h0008,
      S_BLOCK    = 16'h0010,
      S_SCHED0   = 16'h0020,
      S_REQUEUE  = 16'h0040,
      S_IDLECHK  = 16'h0080,
      S_IDLEWAKE = 16'h0100,
      S_POPCHK   = 16'h0200,
      S_POP      = 16'h0400,
      S_UNBLOCK  = 16'h0800,
      S_EXIT     = 16'h1000,
      S_EXIT2    = 16'h2000,
      S_QUERY    = 16'h4000,
      S_FINISH   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               OP_CREATE: state_in = S_SCAN;
               OP_SCHED:  state_in = S_SCHED0;
               OP_BLOCK: begin
                  if (status.cur_valid) begin
                     state_in = S_BLOCK;
                  end else begin
                     cmd      = CMD_ERR_UNKNOWN;
                     state_in = S_FINISH;
                  end
               end
               OP_YIELD: state_in = status.cur_valid ? S_REQUEUE : S_IDLECHK;
               OP_UNBLOCK, OP_EXIT, OP_QUERY: begin
                  if (status.tgt_found) begin
                     cmd = CMD_RD_TGT;
                     if (status.op == OP_UNBLOCK) state_in = S_UNBLOCK;
                     else if (status.op == OP_EXIT) state_in = S_EXIT;
                     else state_in = S_QUERY;
                  end else begin
                     cmd      = CMD_ERR_UNKNOWN;
                     state_in = S_FINISH;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            cmd = CMD_SCAN;
            if (status.scan_hit) state_in = S_CREATE;
            else if (status.scan_last) state_in = S_FINISH;
         end
         S_CREATE: begin
            cmd      = CMD_CREATE;
            state_in = S_FINISH;
         end
         S_BLOCK: begin
            cmd      = CMD_BLOCK;
            state_in = S_IDLECHK;
         end
         S_SCHED0: state_in = status.cur_valid ? S_REQUEUE : S_IDLECHK;
         S_REQUEUE: begin
            cmd      = CMD_REQUEUE;
            state_in = S_IDLECHK;
         end
         S_IDLECHK: begin
            if (!status.count_zero) begin
               cmd      = CMD_RD_HEAD;
               state_in = S_POP;
            end else if (status.idle_found) begin
               cmd      = CMD_RD_IDLE;
               state_in = S_IDLEWAKE;
            end else begin
               cmd      = CMD_SCHED_FAIL;
               state_in = S_FINISH;
            end
         end
         S_IDLEWAKE: begin
            cmd      = CMD_IDLE_WAKE;
            state_in = S_POPCHK;
         end
         S_POPCHK: begin
            if (status.count_zero) begin
               cmd      = CMD_SCHED_FAIL;
               state_in = S_FINISH;
            end else begin
               cmd      = CMD_RD_HEAD;
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd      = CMD_POP;
            state_in = S_FINISH;
         end
         S_UNBLOCK: begin
            cmd      = CMD_UNBLOCK;
            state_in = S_FINISH;
         end
         S_EXIT: begin
            cmd      = CMD_EXIT;
            state_in = S_EXIT2;
         end
         S_EXIT2: state_in = status.need ? S_SCHED0 : S_FINISH;
         S_QUERY: begin
            cmd      = CMD_QUERY;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd      = CMD_LOAD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `RRTS_ASSERT_NXT(a_finish_ret, clock, reset, state_ff == S_FINISH && !status.rsp_busy, state_ff == S_IDLE)
   `RRTS_ASSERT_NXT(a_pop_done, clock, reset, state_ff == S_POP, state_ff == S_FINISH)
   `RRTS_ASSERT_NXT(a_scan_stay, clock, reset, state_ff == S_SCAN && !status.scan_hit && !status.scan_last, state_ff == S_SCAN)

endmodule

/* src/rrts_datapath.sv */
`include "round_robin_task_scheduler_macros.svh"

module rrts_datapath import rrts_pkg::*; #(
   parameter int TASK_SLOTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PID_W-1:0]     csr_data,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [PID_W-1:0]     req_task_pid,
   input  logic [PRIO_W-1:0]    req_priority_req,
   input  logic                 req_start_running,
   input  logic [KIND_W-1:0]    req_block_kind,
   input  logic                 req_need_schedule,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ERR_W-1:0]     rsp_error_code,
   output logic [PID_W-1:0]     rsp_result_pid,
   output logic [PID_W-1:0]     rsp_running_pid,
   output logic [PID_W-1:0]     rsp_previous_pid,
   output logic                 rsp_switched,
   output logic [TST_W-1:0]     rsp_task_status,
   output logic [PRIO_W-1:0]    rsp_task_priority,
   output logic [PRIO_W-1:0]    rsp_slice_left,
   input  cmd_type              cmd,
   output dp_status_type        status
);

   localparam int SW  = $clog2(TASK_SLOTS);
   localparam int CW  = $clog2(TASK_SLOTS + 1);
   localparam int NCH = (TASK_SLOTS + SCAN_W - 1) / SCAN_W;
   localparam int SCW = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int FW  = SCW + $clog2(SCAN_W);

   logic [PID_W-1:0]      pid_base_ff, pid_base_in, idle_pid_ff, idle_pid_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [PID_W-1:0]      tpid_ff, tpid_in;
   logic [PRIO_W-1:0]     prio_req_ff, prio_req_in;
   logic                  start_ff, start_in, need_ff, need_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [TASK_SLOTS-1:0] in_use_ff, in_use_in, in_ready_ff, in_ready_in;
   logic [SW-1:0]         head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  cv_ff, cv_in;
   logic [PRIO_W-1:0]     cur_prio_ff, cur_prio_in, cur_slice_ff, cur_slice_in;
   logic [SCW-1:0]        scan_ff, scan_in;
   logic [SW-1:0]         free_ff, free_in;
   logic [ERR_W-1:0]      err_ff, err_in;
   logic [PID_W-1:0]      rpid_ff, rpid_in, prev_ff, prev_in;
   logic                  sw_ff, sw_in;
   logic [TST_W-1:0]      qst_ff, qst_in;
   logic [PRIO_W-1:0]     qpri_ff, qpri_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ERR_W-1:0]      o_err_ff, o_err_in;
   logic [PID_W-1:0]      o_rpid_ff, o_rpid_in, o_run_ff, o_run_in, o_prev_ff, o_prev_in;
   logic                  o_sw_ff, o_sw_in;
   logic [TST_W-1:0]      o_qst_ff, o_qst_in;
   logic [PRIO_W-1:0]     o_qpri_ff, o_qpri_in, o_slice_ff, o_slice_in;

   logic [TST_W-1:0]  status_mem [TASK_SLOTS];
   logic [PRIO_W-1:0] prio_mem   [TASK_SLOTS];
   logic [PRIO_W-1:0] slice_mem  [TASK_SLOTS];
   logic [SW-1:0]     next_mem   [TASK_SLOTS];
   logic [SW-1:0]     prev_mem   [TASK_SLOTS];

   logic [TST_W-1:0]  rd_status_ff;
   logic [PRIO_W-1:0] rd_prio_ff, rd_slice_ff;
   logic [SW-1:0]     rd_next_ff, rd_prev_ff;
   logic              rd_en;
   logic [SW-1:0]     rd_addr;

   logic              st_we, pr_we, sl_we, nx_we, pv_we;
   logic [SW-1:0]     st_wa, pr_wa, sl_wa, nx_wa, pv_wa;
   logic [TST_W-1:0]  st_wd;
   logic [PRIO_W-1:0] pr_wd, sl_wd;
   logic [SW-1:0]     nx_wd, pv_wd;

   logic              app_en, push_en, rem_en;
   logic [SW-1:0]     ls;

   logic [PID_W-1:0]  tgt_diff, idle_diff;
   logic [SW-1:0]     tgt_slot, idle_slot;
   logic              tgt_found, idle_found, rd_blocked;

   logic [NCH*SCAN_W-1:0] free_pad;
   logic [SCAN_W-1:0]     chunk;
   logic [FW-SCW-1:0]     chunk_bit;
   logic                  scan_hit;
   logic [FW-1:0]         scan_wide;
   logic [KIND_W-1:0]     kind_sat;

   function automatic logic [PID_W-1:0] slot_pid(input logic [SW-1:0] s,
                                                 input logic [PID_W-1:0] base);
      return {{(PID_W-SW){1'b0}}, s} + base;
   endfunction

   assign tgt_diff   = tpid_ff - pid_base_ff;
   assign idle_diff  = idle_pid_ff - pid_base_ff;
   assign tgt_slot   = tgt_diff[SW-1:0];
   assign idle_slot  = idle_diff[SW-1:0];
   assign tgt_found  = (tgt_diff < PID_W'(TASK_SLOTS)) && in_use_ff[tgt_slot];
   assign idle_found = (idle_diff < PID_W'(TASK_SLOTS)) && in_use_ff[idle_slot];
   assign rd_blocked = (rd_status_ff >= TS_BLOCKED) && (rd_status_ff <= TS_HANGING);
   assign kind_sat   = (kind_ff == KIND_EXTRA) ? KIND_HANG : kind_ff;

   for (genvar g = 0; g < NCH * SCAN_W; g++) begin : g_pad
      if (g < TASK_SLOTS) begin : g_real
         assign free_pad[g] = ~in_use_ff[g];
      end else begin : g_fill
         assign free_pad[g] = 1'b0;
      end
   end

   assign chunk    = free_pad[scan_ff*SCAN_W +: SCAN_W];
   assign scan_hit = |chunk;

   always_comb begin
      chunk_bit = '0;
      for (int b = SCAN_W - 1; b >= 0; b--) begin
         if (chunk[b]) chunk_bit = (FW-SCW)'(b);
      end
   end

   assign scan_wide = {scan_ff, chunk_bit};

   always_comb begin
      pid_base_in  = pid_base_ff;
      idle_pid_in  = idle_pid_ff;
      op_in        = op_ff;
      tpid_in      = tpid_ff;
      prio_req_in  = prio_req_ff;
      start_in     = start_ff;
      need_in      = need_ff;
      kind_in      = kind_ff;
      in_use_in    = in_use_ff;
      in_ready_in  = in_ready_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      cv_in        = cv_ff;
      cur_prio_in  = cur_prio_ff;
      cur_slice_in = cur_slice_ff;
      scan_in      = scan_ff;
      free_in      = free_ff;
      err_in       = err_ff;
      rpid_in      = rpid_ff;
      prev_in      = prev_ff;
      sw_in        = sw_ff;
      qst_in       = qst_ff;
      qpri_in      = qpri_ff;
      rsp_valid_in = rsp_valid_ff;
      o_err_in     = o_err_ff;
      o_rpid_in    = o_rpid_ff;
      o_run_in     = o_run_ff;
      o_prev_in    = o_prev_ff;
      o_sw_in      = o_sw_ff;
      o_qst_in     = o_qst_ff;
      o_qpri_in    = o_qpri_ff;
      o_slice_in   = o_slice_ff;
      rd_en = 1'b0;  rd_addr = head_ff;
      st_we = 1'b0;  st_wa = cur_ff;  st_wd = TS_READY;
      pr_we = 1'b0;  pr_wa = free_ff; pr_wd = prio_req_ff;
      sl_we = 1'b0;  sl_wa = free_ff; sl_wd = prio_req_ff;
      nx_we = 1'b0;  nx_wa = tail_ff; nx_wd = cur_ff;
      pv_we = 1'b0;  pv_wa = cur_ff;  pv_wd = tail_ff;
      app_en = 1'b0; push_en = 1'b0; rem_en = 1'b0; ls = cur_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_PID_BASE: pid_base_in = csr_data;
            CSR_IDLE_PID: idle_pid_in = csr_data;
            default: ;
         endcase
      end

      // drop the result once it has been taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (cmd)
         CMD_CAPTURE: begin
            op_in       = req_opcode;
            tpid_in     = req_task_pid;
            prio_req_in = req_priority_req;
            start_in    = req_start_running;
            kind_in     = req_block_kind;
            need_in     = req_need_schedule;
            err_in      = ERR_OK;
            rpid_in     = (req_opcode == OP_QUERY) ? req_task_pid : '0;
            sw_in       = 1'b0;
            qst_in      = '0;
            qpri_in     = '0;
            prev_in     = cv_ff ? slot_pid(cur_ff, pid_base_ff) : '0;
            scan_in     = '0;
         end
         CMD_ERR_UNKNOWN: begin
            err_in = ERR_UNKNOWN;
            if (op_ff == OP_QUERY) qst_in = TS_ABSENT;
         end
         CMD_SCAN: begin
            if (scan_hit) begin
               free_in = scan_wide[SW-1:0];
            end else begin
               scan_in = scan_ff + SCW'(1);
               if (scan_ff == SCW'(NCH - 1)) err_in = ERR_NO_ID;
            end
         end
         CMD_CREATE: begin
            in_use_in[free_ff] = 1'b1;
            pr_we   = 1'b1;
            sl_we   = 1'b1;
            rpid_in = slot_pid(free_ff, pid_base_ff);
            st_we   = 1'b1;
            st_wa   = free_ff;
            if (start_ff && !cv_ff) begin
               st_wd        = TS_RUN;
               cur_in       = free_ff;
               cv_in        = 1'b1;
               cur_prio_in  = prio_req_ff;
               cur_slice_in = prio_req_ff;
            end else begin
               st_wd  = TS_READY;
               app_en = 1'b1;
               ls     = free_ff;
            end
         end
         CMD_BLOCK: begin
            st_we = 1'b1;
            st_wa = cur_ff;
            st_wd = TS_BLOCKED + TST_W'(kind_sat);
         end
         CMD_REQUEUE: begin
            st_we = 1'b1;
            st_wa = cur_ff;
            st_wd = TS_READY;
            // a yield keeps the slice it has left
            if (op_ff != OP_YIELD) begin
               sl_we = 1'b1;
               sl_wa = cur_ff;
               sl_wd = cur_prio_ff;
            end
            app_en = 1'b1;
            ls     = cur_ff;
         end
         CMD_RD_TGT: begin
            rd_en   = 1'b1;
            rd_addr = tgt_slot;
         end
         CMD_RD_IDLE: begin
            rd_en   = 1'b1;
            rd_addr = idle_slot;
         end
         CMD_RD_HEAD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         CMD_IDLE_WAKE: begin
            if (rd_blocked) begin
               push_en = 1'b1;
               ls      = idle_slot;
               st_we   = 1'b1;
               st_wa   = idle_slot;
               st_wd   = TS_READY;
            end
         end
         CMD_UNBLOCK: begin
            if (rd_blocked) begin
               push_en = 1'b1;
               ls      = tgt_slot;
               st_we   = 1'b1;
               st_wa   = tgt_slot;
               st_wd   = TS_READY;
            end else begin
               err_in = ERR_NOT_BLOCKED;
            end
         end
         CMD_POP: begin
            rem_en       = 1'b1;
            ls           = head_ff;
            st_we        = 1'b1;
            st_wa        = head_ff;
            st_wd        = TS_RUN;
            cur_in       = head_ff;
            cv_in        = 1'b1;
            cur_prio_in  = rd_prio_ff;
            cur_slice_in = rd_slice_ff;
            sw_in        = !cv_ff || (cur_ff != head_ff);
            err_in       = ERR_OK;
         end
         CMD_SCHED_FAIL: begin
            err_in = ERR_NOTHING;
            cv_in  = 1'b0;
            sw_in  = cv_ff;
         end
         CMD_EXIT: begin
            if (in_ready_ff[tgt_slot]) begin
               rem_en = 1'b1;
               ls     = tgt_slot;
            end
            st_we = 1'b1;
            st_wa = tgt_slot;
            st_wd = TS_DIED;
            in_use_in[tgt_slot] = 1'b0;
            if (cv_ff && cur_ff == tgt_slot) cv_in = 1'b0;
         end
         CMD_QUERY: begin
            qst_in  = rd_status_ff;
            qpri_in = rd_prio_ff;
         end
         CMD_LOAD_OUT: begin
            rsp_valid_in = 1'b1;
            o_err_in     = err_ff;
            o_rpid_in    = rpid_ff;
            o_run_in     = cv_ff ? slot_pid(cur_ff, pid_base_ff) : '0;
            o_prev_in    = prev_ff;
            o_sw_in      = sw_ff;
            o_qst_in     = qst_ff;
            o_qpri_in    = qpri_ff;
            o_slice_in   = cv_ff ? cur_slice_ff : '0;
         end
         default: ;
      endcase

      if (app_en) begin
         if (count_ff == '0) begin
            head_in = ls;
         end else begin
            nx_we = 1'b1; nx_wa = tail_ff; nx_wd = ls;
            pv_we = 1'b1; pv_wa = ls;      pv_wd = tail_ff;
         end
         tail_in         = ls;
         in_ready_in[ls] = 1'b1;
         count_in        = count_ff + CW'(1);
      end
      if (push_en) begin
         if (count_ff == '0) begin
            tail_in = ls;
         end else begin
            pv_we = 1'b1; pv_wa = head_ff; pv_wd = ls;
            nx_we = 1'b1; nx_wa = ls;      nx_wd = head_ff;
         end
         head_in         = ls;
         in_ready_in[ls] = 1'b1;
         count_in        = count_ff + CW'(1);
      end
      if (rem_en) begin
         // unlink using the links read in the previous cycle
         if (ls == head_ff) begin
            head_in = rd_next_ff;
         end else begin
            nx_we = 1'b1; nx_wa = rd_prev_ff; nx_wd = rd_next_ff;
         end
         if (ls == tail_ff) begin
            tail_in = rd_prev_ff;
         end else begin
            pv_we = 1'b1; pv_wa = rd_next_ff; pv_wd = rd_prev_ff;
         end
         in_ready_in[ls] = 1'b0;
         count_in        = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) status_mem[st_wa] <= st_wd;
      if (pr_we) prio_mem[pr_wa]   <= pr_wd;
      if (sl_we) slice_mem[sl_wa]  <= sl_wd;
      if (nx_we) next_mem[nx_wa]   <= nx_wd;
      if (pv_we) prev_mem[pv_wa]   <= pv_wd;
      if (rd_en) begin
         rd_status_ff <= status_mem[rd_addr];
         rd_prio_ff   <= prio_mem[rd_addr];
         rd_slice_ff  <= slice_mem[rd_addr];
         rd_next_ff   <= next_mem[rd_addr];
         rd_prev_ff   <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_base_ff  <= PID_W'(1);
         idle_pid_ff  <= PID_W'(3);
         in_use_ff    <= '0;
         in_ready_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cur_ff       <= '0;
         count_ff     <= '0;
         cv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pid_base_ff  <= pid_base_in;
         idle_pid_ff  <= idle_pid_in;
         in_use_ff    <= in_use_in;
         in_ready_ff  <= in_ready_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         cv_ff        <= cv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tpid_ff      <= tpid_in;
      prio_req_ff  <= prio_req_in;
      start_ff     <= start_in;
      need_ff      <= need_in;
      kind_ff      <= kind_in;
      cur_prio_ff  <= cur_prio_in;
      cur_slice_ff <= cur_slice_in;
      scan_ff      <= scan_in;
      free_ff      <= free_in;
      err_ff       <= err_in;
      rpid_ff      <= rpid_in;
      prev_ff      <= prev_in;
      sw_ff        <= sw_in;
      qst_ff       <= qst_in;
      qpri_ff      <= qpri_in;
      o_err_ff     <= o_err_in;
      o_rpid_ff    <= o_rpid_in;
      o_run_ff     <= o_run_in;
      o_prev_ff    <= o_prev_in;
      o_sw_ff      <= o_sw_in;
      o_qst_ff     <= o_qst_in;
      o_qpri_ff    <= o_qpri_in;
      o_slice_ff   <= o_slice_in;
   end

   assign status.op         = op_ff;
   assign status.cur_valid  = cv_ff;
   assign status.tgt_found  = tgt_found;
   assign status.idle_found = idle_found;
   assign status.count_zero = (count_ff == '0);
   assign status.scan_hit   = scan_hit;
   assign status.scan_last  = (scan_ff == SCW'(NCH - 1));
   assign status.need       = need_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_error_code    = o_err_ff;
   assign rsp_result_pid    = o_rpid_ff;
   assign rsp_running_pid   = o_run_ff;
   assign rsp_previous_pid  = o_prev_ff;
   assign rsp_switched      = o_sw_ff;
   assign rsp_task_status   = o_qst_ff;
   assign rsp_task_priority = o_qpri_ff;
   assign rsp_slice_left    = o_slice_ff;

   `RRTS_ASSERT_IMP(a_empty_no_ready, clock, reset, count_ff == '0, in_ready_ff == '0)
   `RRTS_ASSERT_IMP(a_cur_in_use, clock, reset, cv_ff, in_use_ff[cur_ff])
   `RRTS_ASSERT_NXT(a_load_valid, clock, reset, cmd == CMD_LOAD_OUT, rsp_valid_ff)

endmodule
